// ===== rtl/rotation_matrix_to_euler_top_assert.svh =====
// Assertion macros for the rotation matrix to Euler angle pipeline
`ifndef ROTATION_MATRIX_TO_EULER_TOP_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RME_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define RME_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define RME_ASSERT_IMPL(label, clk, rst_n, a, c)
`define RME_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/rme_pkg.sv =====
// Shared constants, types and tables for the Euler angle pipeline
`timescale 1ns / 1ps
package rme_pkg;
	localparam int CORDIC_STEPS = 31;
	localparam int SQRT_STAGES = 28;
	localparam int ZW = 34;
	localparam int XW = 34;
	localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	function automatic logic signed [ZW-1:0] atan_tab(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: r = (i < CORDIC_STEPS) ? (ZW'(1) <<< (30 - i)) : '0;
		endcase
		return r;
	endfunction
endpackage

// ===== rtl/rme_sqrt.sv =====
// Pipelined restoring square root of a 56-bit operand, one result bit a stage
`timescale 1ns / 1ps
module rme_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [55:0] radicand,
	output logic [27:0] root
);
	logic [55:0] rem_s  [0:28];
	logic [27:0] res_s  [0:28];

	always_comb begin
		rem_s[0] = radicand;
		res_s[0] = '0;
	end

	for (genvar k = 0; k < 28; k++) begin : g_bit
		localparam int B = 27 - k;
		logic [55:0] trial;
		logic [27:0] cand;
		always_comb begin
			cand  = res_s[k] | (28'd1 << B);
			trial = 56'(cand) * 56'(cand);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				res_s[k+1] <= '0;
				rem_s[k+1] <= '0;
			end else if (en) begin
				rem_s[k+1] <= rem_s[k];
				res_s[k+1] <= (trial <= rem_s[k]) ? cand : res_s[k];
			end
		end
	end
	assign root = res_s[28];
endmodule

// ===== rtl/rme_cordic.sv =====
// Pipelined vectoring CORDIC atan2 with Q30 angle and Q13 rounding
`timescale 1ns / 1ps
module rme_cordic #(
	parameter bit NEG = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic signed [31:0]  y_in,
	input  logic signed [31:0]  x_in,
	output logic signed [15:0]  angle
);
	rme_pkg::cordic_t st_s [0:rme_pkg::CORDIC_STEPS];
	logic signed [rme_pkg::XW-1:0] nx, ny, mag, ay;
	logic signed [rme_pkg::ZW-1:0] z0;
	logic zero_s1;
	logic [4:0] sh;

	// fold to right half-plane and normalize
	always_comb begin
		nx = rme_pkg::XW'(x_in);
		ny = rme_pkg::XW'(y_in);
		z0 = '0;
		if (x_in < 0) begin
			z0 = (y_in >= 0) ? rme_pkg::PI_Q30 : -rme_pkg::PI_Q30;
			nx = -nx;
			ny = -ny;
		end
		ay  = (ny < 0) ? -ny : ny;
		mag = (nx > ay) ? nx : ay;
		sh = '0;
		for (int b = 29; b >= 0; b--)
			if (mag[b] && sh == 0 && mag < (rme_pkg::XW'(1) <<< 29)) sh = 5'(29 - b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s[0] <= '0;
		end else if (en) begin
			st_s[0].x <= nx <<< sh;
			st_s[0].y <= ny <<< sh;
			st_s[0].z <= z0;
		end
	end

	for (genvar i = 0; i < rme_pkg::CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st_s[i+1] <= '0;
			end else if (en) begin
				if (st_s[i].y >= 0) begin
					st_s[i+1].x <= st_s[i].x + (st_s[i].y >>> i);
					st_s[i+1].y <= st_s[i].y - (st_s[i].x >>> i);
					st_s[i+1].z <= st_s[i].z + rme_pkg::atan_tab(i);
				end else begin
					st_s[i+1].x <= st_s[i].x - (st_s[i].y >>> i);
					st_s[i+1].y <= st_s[i].y + (st_s[i].x >>> i);
					st_s[i+1].z <= st_s[i].z - rme_pkg::atan_tab(i);
				end
			end
		end
	end

	// track the both-zero case alongside the stages
	logic [rme_pkg::CORDIC_STEPS:0] zero_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) zero_q <= '0;
		else if (en) zero_q <= {zero_q[rme_pkg::CORDIC_STEPS-1:0], (x_in == 0 && y_in == 0)};
	end
	assign zero_s1 = zero_q[rme_pkg::CORDIC_STEPS];

	// negate in Q30 before rounding so a tie rounds the same way as the negated angle
	logic signed [rme_pkg::ZW-1:0] zf, zr;
	always_comb begin
		zf = NEG ? -st_s[rme_pkg::CORDIC_STEPS].z : st_s[rme_pkg::CORDIC_STEPS].z;
		zr = (zf + (rme_pkg::ZW'(1) <<< 16)) >>> 17;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) angle <= '0;
		else if (en) angle <= zero_s1 ? '0 : 16'(zr);
	end
endmodule

// ===== rtl/rotation_matrix_to_euler_top.sv =====
// Top level: rotation matrix to X-Y-Z Euler angle pipeline
//
// Usage:
//  s_axis carries one request per matrix: seven signed Q1.14 entries.
//  m_tdata returns angle_x and angle_z (signed Q2.13 radians), angle_y (signed Q1.13) and
//  the gimbal-lock flag in tuser.
//  Throughput: one request per clock unless the receiver stalls. The path runs
//  through the 28-stage square root, one align stage and the 33-stage CORDIC for
//  the pitch angle; the x and z CORDICs run in parallel and are delay-matched.
//  The whole pipeline advances together when the output register is free
//  or being drained; when the receiver stalls, every stage holds and
//  s_tready drops, so nothing is lost or repeated.
//  Reset clears all valid bits; no request is in flight afterward.
//  Gimbal lock (m20 exactly +-1): z is 0, y is -+pi/2 and x is
//  atan2(m01, m02).
//
`timescale 1ns / 1ps
`include "rotation_matrix_to_euler_top_assert.svh"
module rotation_matrix_to_euler_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,  // m00, m01, m02, m10, m20, m21, m22
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,  // angle_x, angle_y, angle_z, 1'b0 pad
	output logic         m_tuser   // gimbal_lock
);
	localparam int SQRT_LAT = rme_pkg::SQRT_STAGES;
	localparam int CLAT = rme_pkg::CORDIC_STEPS + 2;
	localparam int LAT = SQRT_LAT + 1 + CLAT;

	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [15:0] m00, m01, m02, m10, m20, m21, m22;
	assign {m22, m21, m20, m10, m02, m01, m00} = s_tdata;

	logic lock;
	assign lock = (m20 == rme_pkg::ONE_Q14) || (m20 == -rme_pkg::ONE_Q14);

	// cosine squared in Q28, radicand shifted into Q56
	logic signed [31:0] sq;
	logic [55:0] rad;
	logic [27:0] root;
	assign sq  = 32'sd268435456 - 32'(m20) * 32'(m20);
	assign rad = (sq > 0 && !lock) ? {sq[27:0], 28'd0} : '0;

	rme_sqrt u_sqrt (.clk, .arst_n, .en, .radicand(rad), .root(root));

	// delay the operands while the root forms
	logic signed [15:0] d_m20 [0:SQRT_LAT];
	logic signed [15:0] d_ax_y [0:SQRT_LAT];
	logic signed [15:0] d_ax_x [0:SQRT_LAT];
	logic signed [15:0] d_az_y [0:SQRT_LAT];
	logic signed [15:0] d_az_x [0:SQRT_LAT];
	logic d_lock [0:SQRT_LAT];
	always_comb begin
		d_m20[0] = m20;
		d_ax_y[0] = lock ? m01 : m21;
		d_ax_x[0] = lock ? m02 : m22;
		d_az_y[0] = m10;
		d_az_x[0] = m00;
		d_lock[0] = lock;
	end
	for (genvar k = 0; k < SQRT_LAT; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				d_m20[k+1] <= d_m20[k];
				d_ax_y[k+1] <= d_ax_y[k];
				d_ax_x[k+1] <= d_ax_x[k];
				d_az_y[k+1] <= d_az_y[k];
				d_az_x[k+1] <= d_az_x[k];
				d_lock[k+1] <= d_lock[k];
			end
		end
	end

	// align stage: root for in-range m20, clamp otherwise
	logic signed [31:0] cy_s1, cx_s1, axy_s1, axx_s1, azy_s1, azx_s1;
	logic lock_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			cy_s1  <= 32'(d_m20[SQRT_LAT]) <<< 14;
			cx_s1  <= 32'($unsigned(root));
			axy_s1 <= 32'(d_ax_y[SQRT_LAT]);
			axx_s1 <= 32'(d_ax_x[SQRT_LAT]);
			azy_s1 <= 32'(d_az_y[SQRT_LAT]);
			azx_s1 <= 32'(d_az_x[SQRT_LAT]);
			lock_s1 <= d_lock[SQRT_LAT];
		end
	end

	logic signed [15:0] ang_x, ang_y, ang_z;
	rme_cordic #(.NEG(1'b0)) u_cx (.clk, .arst_n, .en, .y_in(axy_s1), .x_in(axx_s1),
		.angle(ang_x));
	rme_cordic #(.NEG(1'b1)) u_cy (.clk, .arst_n, .en, .y_in(cy_s1), .x_in(cx_s1),
		.angle(ang_y));
	rme_cordic #(.NEG(1'b0)) u_cz (.clk, .arst_n, .en, .y_in(azy_s1), .x_in(azx_s1),
		.angle(ang_z));

	logic [CLAT-1:0] lk_q;
	always_ff @(posedge clk) begin
		if (en) lk_q <= {lk_q[CLAT-2:0], lock_s1};
	end

	// angle_y is the negated arctangent, negated inside the CORDIC before rounding
	logic signed [14:0] y_out;
	logic lk_out;
	assign lk_out = lk_q[CLAT-1];
	assign y_out = 15'(ang_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], s_tvalid};
	end
	assign m_tvalid = vld_q[LAT-1];
	// lock at stage 1 forces cy to m20 and cx to 0, so atan2 is +-pi/2 there
	assign m_tdata = {1'b0, (lk_out ? 16'sd0 : ang_z), y_out, ang_x};
	assign m_tuser = lk_out;

	`RME_ASSERT_IMPL(a_ready, clk, arst_n, m_tvalid && !m_tready, !s_tready)
	`RME_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`RME_ASSERT_IMPL(a_lockz, clk, arst_n, m_tvalid && m_tuser, m_tdata[46:31] == 16'd0)
endmodule
